>>> hw/rtl/log_record_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// Log record deframer assertion macros
// Shared property forms for the checker of the deframer ports.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_TOP_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// Log record deframer package
// Field constants, register indexes, class codes and shared types.
// ----------------------------------------------------------------------------
package lrd_pkg;

   localparam logic [7:0]  SYNC_BYTE     = 8'h55;
   localparam logic [14:0] PAYLOAD_START = 15'd10;
   localparam logic [15:0] MIN_LENGTH    = 16'd12;

   // Record byte positions of the header fields.
   localparam logic [14:0] POS_SYNC   = 15'd0;
   localparam logic [14:0] POS_LEN_LO = 15'd1;
   localparam logic [14:0] POS_LEN_HI = 15'd2;
   localparam logic [14:0] POS_ID_LO  = 15'd4;
   localparam logic [14:0] POS_ID_HI  = 15'd5;
   localparam logic [14:0] POS_KEY    = 15'd6;

   localparam logic [1:0] CLASS_OTHER    = 2'd0;
   localparam logic [1:0] CLASS_FEEDBACK = 2'd1;
   localparam logic [1:0] CLASS_ATTITUDE = 2'd2;

   localparam logic CSR_FEEDBACK_ID = 1'b0;
   localparam logic CSR_ATTITUDE_ID = 1'b1;

   localparam logic [15:0] FEEDBACK_ID_RESET = 16'd29;
   localparam logic [15:0] ATTITUDE_ID_RESET = 16'd2048;

   typedef struct packed {
      logic [14:0] field_position;
      logic [15:0] record_length;
      logic [15:0] current_id;
      logic [7:0]  xor_key;
      logic        sync_bad;
      logic        drop_rest;
      logic [15:0] packet_counter;
      logic        in_packet;
   } lrd_state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  payload_byte;
      logic [15:0] record_id;
      logic [1:0]  record_class;
      logic [14:0] byte_index;
      logic        record_last;
      logic        frame_error;
      logic [15:0] packet_number;
   } lrd_result_type;

endpackage

>>> hw/rtl/lrd_step.sv
// ----------------------------------------------------------------------------
// Log record deframer byte step
// Combinational update of the record parser for one accepted byte.
// ----------------------------------------------------------------------------
module lrd_step
   import lrd_pkg::*;
(
   input  lrd_state_type  state_cur,
   input  logic [7:0]     in_byte,
   input  logic           packet_end,
   input  logic [15:0]    feedback_id,
   input  logic [15:0]    attitude_id,
   output lrd_state_type  state_nxt,
   output lrd_result_type result
);

   logic        start;
   logic [14:0] pos;
   logic        sync_bad;
   logic        drop;
   logic [15:0] count;
   logic [15:0] len_nxt;
   logic [15:0] len_hi_value;
   logic [15:0] pos_plus3;
   logic [15:0] pos_plus1;
   logic        past_len;
   logic        hdr_err;
   logic        end_err;
   logic        emit;
   logic [1:0]  cls;

   always_comb begin
      start    = !state_cur.in_packet;
      pos      = start ? '0 : state_cur.field_position;
      sync_bad = start ? 1'b0 : state_cur.sync_bad;
      drop     = start ? 1'b0 : state_cur.drop_rest;
      count    = start ? state_cur.packet_counter + 16'd1 : state_cur.packet_counter;

      pos_plus3    = {1'b0, pos} + 16'd3;
      pos_plus1    = {1'b0, pos} + 16'd1;
      past_len     = (pos >= POS_LEN_HI);
      len_hi_value = {in_byte, state_cur.record_length[7:0]};

      len_nxt = state_cur.record_length;
      if (pos == POS_LEN_LO) begin
         len_nxt = {8'h00, in_byte};
      end else if (pos == POS_LEN_HI) begin
         len_nxt = len_hi_value;
      end

      // A length with the top bit set counts as negative and so too short.
      hdr_err = (pos == POS_LEN_HI) &&
                (sync_bad || in_byte[7] || (len_hi_value < MIN_LENGTH));
      end_err = !hdr_err && packet_end && past_len && (pos_plus3 < len_nxt);
      emit    = (pos >= PAYLOAD_START) && (pos_plus3 <= state_cur.record_length);

      if (state_cur.current_id == feedback_id) begin
         cls = CLASS_FEEDBACK;
      end else if (state_cur.current_id == attitude_id) begin
         cls = CLASS_ATTITUDE;
      end else begin
         cls = CLASS_OTHER;
      end

      state_nxt                = state_cur;
      state_nxt.packet_counter = count;
      state_nxt.in_packet      = 1'b1;
      state_nxt.field_position = pos;
      state_nxt.sync_bad       = sync_bad;
      state_nxt.drop_rest      = drop;

      result               = '0;
      result.packet_number = count;

      if (!drop) begin
         state_nxt.record_length = len_nxt;
         if (pos == POS_SYNC) begin
            state_nxt.sync_bad = (in_byte != SYNC_BYTE);
         end
         if (pos == POS_ID_LO) begin
            state_nxt.current_id = {8'h00, in_byte};
         end
         if (pos == POS_ID_HI) begin
            state_nxt.current_id = {in_byte, state_cur.current_id[7:0]};
         end
         if (pos == POS_KEY) begin
            state_nxt.xor_key = in_byte;
         end

         if (hdr_err || end_err) begin
            result.valid        = 1'b1;
            result.frame_error  = 1'b1;
            state_nxt.drop_rest = 1'b1;
         end else begin
            if (emit) begin
               result.valid        = 1'b1;
               result.payload_byte = in_byte ^ state_cur.xor_key;
               result.record_id    = state_cur.current_id;
               result.record_class = cls;
               result.byte_index   = pos - PAYLOAD_START;
               result.record_last  = (pos_plus3 == state_cur.record_length);
            end
            if (past_len && (pos_plus1 == len_nxt)) begin
               state_nxt.field_position = '0;
            end else begin
               state_nxt.field_position = pos_plus1[14:0];
            end
         end
      end

      if (packet_end) begin
         state_nxt.in_packet      = 1'b0;
         state_nxt.field_position = '0;
         state_nxt.sync_bad       = 1'b0;
         state_nxt.drop_rest      = 1'b0;
      end
   end

endmodule

>>> hw/rtl/log_record_deframer_top.sv
// ----------------------------------------------------------------------------
// Log record deframer
// Splits a byte stream of packets into log records and emits decoded payload.
// ----------------------------------------------------------------------------
// Usage:
// Raw packet bytes enter on the req_ stream, one byte per beat, with req_tlast
// on the final byte of each packet. Decoded payload bytes leave on the rsp_
// stream, one beat per payload byte, with rsp_tlast on the last payload byte
// of a record. An error beat (rsp_tuser frame error bit set) marks a bad
// sync byte, a short length or a packet that ends inside a record; the
// record's earlier beats are then void. Header and trailer bytes give no beat.
// The csr_ port writes the two class ids; write it only while the block is
// idle. It is always ready.
// Each byte is parsed in the cycle it is accepted and its result appears on
// the rsp_ port in the next cycle. One byte can be taken every cycle; the
// single output register sets that rate, and the block keeps accepting while
// the receiver takes the pending beat. If the receiver stalls with a beat
// pending, req_tready drops until that beat is taken. Reset clears the parser,
// the packet counter and the output, and restores the default class ids.
// ----------------------------------------------------------------------------
module log_record_deframer_top
   import lrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Byte input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // packet_end
   // Decoded payload output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] payload_byte, [23:8] record_id,
                                    // [38:24] byte_index, [54:39] packet_number
   output logic [2:0]  rsp_tuser,   // [1:0] record_class, [2] frame_error
   output logic        rsp_tlast,   // record_last
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   lrd_state_type  state_ff;
   lrd_state_type  state_in;
   lrd_result_type result_in;
   lrd_result_type result_ff;
   logic [15:0]    feedback_id_ff;
   logic [15:0]    attitude_id_ff;
   logic           req_fire;

   assign req_tready = !result_ff.valid || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   lrd_step u_step (
      .state_cur   (state_ff),
      .in_byte     (req_tdata),
      .packet_end  (req_tlast),
      .feedback_id (feedback_id_ff),
      .attitude_id (attitude_id_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feedback_id_ff <= FEEDBACK_ID_RESET;
         attitude_id_ff <= ATTITUDE_ID_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FEEDBACK_ID: feedback_id_ff <= csr_data;
            CSR_ATTITUDE_ID: attitude_id_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else if (req_fire) begin
         result_ff <= result_in;
      end else if (rsp_tready) begin
         result_ff.valid <= 1'b0;
      end
   end

   assign rsp_tvalid = result_ff.valid;
   assign rsp_tdata  = {1'b0, result_ff.packet_number, result_ff.byte_index,
                        result_ff.record_id, result_ff.payload_byte};
   assign rsp_tuser  = {result_ff.frame_error, result_ff.record_class};
   assign rsp_tlast  = result_ff.record_last;

endmodule

>>> hw/rtl/lrd_checker.sv
// ----------------------------------------------------------------------------
// Log record deframer checker
// Port-level properties of the deframer, bound to its top level.
// ----------------------------------------------------------------------------
`include "log_record_deframer_top_defines.svh"

module lrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // An error beat carries only the packet number.
   `LRD_ASSERT_NOW(a_error_beat_clean, clock, reset, rsp_tvalid && rsp_tuser[2],
      (rsp_tdata[38:0] == 39'd0) && !rsp_tlast && (rsp_tuser[1:0] == 2'd0),
      "error beat carries payload fields")

   `LRD_ASSERT_NOW(a_class_code, clock, reset, rsp_tvalid,
      (rsp_tuser[1:0] != 2'd3) && !rsp_tdata[55],
      "illegal class code or padding bit on result beat")

   // With no beat pending the output register is free, so input must be open.
   `LRD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready,
      "input stalled while no result is pending")

   `LRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result beat changed")

endmodule

bind log_record_deframer_top lrd_checker u_lrd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
